// ----- sv/dmd_pkg.sv -----
// dmd_pkg: shared widths, register map, reset values and config struct
// for the distance motion detector; used by dmd_regs and distance_motion_detector
`default_nettype none

package dmd_pkg;

	localparam int unsigned WINDOW = 5;

	localparam int unsigned DIST_W = 10;
	localparam int unsigned DIFF_W = DIST_W + 1;
	localparam int unsigned SUM_W  = 14;
	localparam int unsigned BAR_W  = 4;
	localparam int unsigned INTV_W = 10;
	localparam int unsigned CFG_W  = 10;
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned IDX_W  = ADDR_W - 2;

	localparam logic [IDX_W-1:0] REG_THRESH = 2'd0;
	localparam logic [IDX_W-1:0] REG_FAST   = 2'd1;
	localparam logic [IDX_W-1:0] REG_STEP   = 2'd2;
	localparam logic [IDX_W-1:0] REG_MAX    = 2'd3;

	localparam logic [CFG_W-1:0] THRESH_RST = 10'd2;
	localparam logic [CFG_W-1:0] FAST_RST   = 10'd50;
	localparam logic [CFG_W-1:0] STEP_RST   = 10'd30;
	localparam logic [CFG_W-1:0] MAX_RST    = 10'd500;

	localparam logic [BAR_W-1:0] BAR_MAX = 4'd15;

	typedef struct packed {
		logic [CFG_W-1:0] change_threshold;
		logic [CFG_W-1:0] fast_interval;
		logic [CFG_W-1:0] interval_step;
		logic [CFG_W-1:0] max_interval;
	} cfg_t;

endpackage

`default_nettype wire

// ----- sv/dmd_regs.sv -----
// dmd_regs: apb register file holding the four configuration registers
// depends on dmd_pkg
`default_nettype none

module dmd_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [dmd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [dmd_pkg::DATA_W-1:0] pwdata,
	output logic      [dmd_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output dmd_pkg::cfg_t                   cfg
);
	import dmd_pkg::*;

	cfg_t             cfg_q;
	logic [IDX_W-1:0] idx;
	logic             wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.change_threshold <= THRESH_RST;
			cfg_q.fast_interval    <= FAST_RST;
			cfg_q.interval_step    <= STEP_RST;
			cfg_q.max_interval     <= MAX_RST;
		end else if (wr_en) begin
			case (idx)
				REG_THRESH: cfg_q.change_threshold <= pwdata[CFG_W-1:0];
				REG_FAST:   cfg_q.fast_interval    <= pwdata[CFG_W-1:0];
				REG_STEP:   cfg_q.interval_step    <= pwdata[CFG_W-1:0];
				REG_MAX:    cfg_q.max_interval     <= pwdata[CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_THRESH: prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_q.change_threshold};
			REG_FAST:   prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_q.fast_interval};
			REG_STEP:   prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_q.interval_step};
			REG_MAX:    prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_q.max_interval};
			default:    prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/distance_motion_detector.sv -----
// distance_motion_detector: top level, input register, change and interval
// logic, history shift lines and result register; depends on dmd_pkg, dmd_regs
`default_nettype none

// One distance sample per item gives one result item. A sample sits in the
// input register, where the change against the previous sample, the long-move
// check over the last WINDOW change magnitudes, the windowed change sum, the
// level bar and the next sampling interval are formed, and then lands in the
// result register. A new item is taken every cycle while out_stall is low;
// while one result waits in the output register, the input register still
// takes one item, then in_stall rises. The user must write configuration over
// the apb port only while no item is in flight; the block does not enforce it.
module distance_motion_detector (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [dmd_pkg::DIST_W-1:0] distance,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            distance_changed,
	output logic                            long_move,
	output logic signed [dmd_pkg::SUM_W-1:0] change_sum,
	output logic      [dmd_pkg::BAR_W-1:0]  bar_length,
	output logic      [dmd_pkg::INTV_W-1:0] next_interval,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [dmd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [dmd_pkg::DATA_W-1:0] pwdata,
	output logic      [dmd_pkg::DATA_W-1:0] prdata,
	output logic                            pready
);
	import dmd_pkg::*;

	cfg_t cfg;

	logic              s1_valid_q;
	logic [DIST_W-1:0] dist_s1;
	logic              out_valid_q;
	logic              changed_s2;
	logic              long_s2;
	logic [SUM_W-1:0]  sum_s2;
	logic [BAR_W-1:0]  bar_s2;
	logic [INTV_W-1:0] intv_s2;

	logic [DIST_W-1:0] dist_hist_q [WINDOW];
	logic [DIST_W-1:0] mag_hist_q  [WINDOW];
	logic [INTV_W-1:0] interval_q;

	logic              advance;
	logic              move_s1;
	logic              accept;
	logic [DIFF_W-1:0] change;
	logic [DIST_W-1:0] mag;
	logic              changed;
	logic              history_long;
	logic [DIFF_W-1:0] window_diff;
	logic [SUM_W-1:0]  sum;
	logic [BAR_W-1:0]  bar;
	logic [INTV_W:0]   stepped;
	logic [INTV_W-1:0] interval_nxt;

	dmd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake
	assign advance  = !out_valid_q || !out_stall;
	assign move_s1  = s1_valid_q && advance;
	assign in_stall = s1_valid_q && !advance;
	assign accept   = in_valid && !in_stall;

	// change against the previous sample and its magnitude
	assign change = {1'b0, dist_s1} - {1'b0, dist_hist_q[0]};
	assign mag    = change[DIFF_W-1] ? (~change[DIST_W-1:0] + 1'b1) : change[DIST_W-1:0];
	assign changed = mag > cfg.change_threshold;

	always_comb begin
		history_long = 1'b1;
		for (int i = 0; i < WINDOW; i++) begin
			if (mag_hist_q[i] <= cfg.change_threshold)
				history_long = 1'b0;
		end
	end

	// windowed change sum telescopes to a difference of two samples
	assign window_diff = {1'b0, dist_s1} - {1'b0, dist_hist_q[WINDOW-1]};
	assign sum = {{(SUM_W-DIFF_W){window_diff[DIFF_W-1]}}, window_diff};

	assign bar = (dist_s1[DIST_W-1:BAR_W+2] != '0) ? BAR_MAX : dist_s1[BAR_W+1:2];

	assign stepped = {1'b0, interval_q} + {1'b0, cfg.interval_step};

	always_comb begin
		if (changed)
			interval_nxt = cfg.fast_interval;
		else if (interval_q < cfg.max_interval)
			interval_nxt = (stepped > {1'b0, cfg.max_interval}) ? cfg.max_interval
				: stepped[INTV_W-1:0];
		else
			interval_nxt = interval_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				s1_valid_q <= 1'b1;
			else if (advance)
				s1_valid_q <= 1'b0;
			if (advance)
				out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			dist_s1 <= distance;
		if (move_s1) begin
			changed_s2 <= changed;
			long_s2    <= changed && history_long;
			sum_s2     <= sum;
			bar_s2     <= bar;
			intv_s2    <= interval_nxt;
		end
	end

	// sample history, magnitude history and interval state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				dist_hist_q[i] <= '0;
				mag_hist_q[i]  <= '0;
			end
			interval_q <= MAX_RST;
		end else if (move_s1) begin
			for (int i = 1; i < WINDOW; i++) begin
				dist_hist_q[i] <= dist_hist_q[i-1];
				mag_hist_q[i]  <= mag_hist_q[i-1];
			end
			dist_hist_q[0] <= dist_s1;
			mag_hist_q[0]  <= mag;
			interval_q     <= interval_nxt;
		end
	end

	assign out_valid        = out_valid_q;
	assign distance_changed = changed_s2;
	assign long_move        = long_s2;
	assign change_sum       = sum_s2;
	assign bar_length       = bar_s2;
	assign next_interval    = intv_s2;

`ifndef NO_ASSERTIONS
	a_long_needs_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && long_move |-> distance_changed)
		else $error("long move without change");

	a_fast_after_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && distance_changed |-> next_interval == cfg.fast_interval)
		else $error("interval not fast after change");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_q && out_valid_q)
		else $error("input stalled with free stage");

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> change_sum >= -14'sd1023 && change_sum <= 14'sd1023)
		else $error("change sum out of range");
`endif

endmodule

`default_nettype wire

// ----- sim/distance_motion_detector_test.sv -----
// distance_motion_detector_test: self-checking bench for the distance motion detector;
// a scoreboard class predicts every result from the samples, apb writes change the setup
// depends on dmd_pkg and distance_motion_detector
`timescale 1ns / 100ps

module distance_motion_detector_test;
	import dmd_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 8;
	localparam int SAMPLES_PER_SETTING = 100;

	typedef struct packed {
		logic                     distance_changed;
		logic                     long_move;
		logic signed [SUM_W-1:0]  change_sum;
		logic [BAR_W-1:0]         bar_length;
		logic [INTV_W-1:0]        next_interval;
	} motion_result_t;

	class motion_scoreboard;
		logic [CFG_W-1:0] thresh, fast, step, ceiling;
		logic [DIST_W-1:0] last_dist;
		logic signed [DIFF_W-1:0] moves [WINDOW];
		logic [INTV_W-1:0] interval;
		motion_result_t pending_q [$];
		int errors, checked, n_changed, n_long;

		function new();
			thresh = THRESH_RST;
			fast = FAST_RST;
			step = STEP_RST;
			ceiling = MAX_RST;
			last_dist = '0;
			foreach (moves[i]) moves[i] = '0;
			interval = MAX_RST;
			errors = 0;
			checked = 0;
			n_changed = 0;
			n_long = 0;
		endfunction

		function void set_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_THRESH: thresh = v;
				REG_FAST: fast = v;
				REG_STEP: step = v;
				REG_MAX: ceiling = v;
				default: ;
			endcase
		endfunction

		function int magnitude(int v);
			return v < 0 ? -v : v;
		endfunction

		function void note_sample(logic [DIST_W-1:0] d);
			int delta, total, nxt, bar;
			bit changed, longmv;
			motion_result_t r;
			delta = int'(d) - int'(last_dist);
			changed = magnitude(delta) > int'(thresh);
			longmv = changed;
			total = delta;
			for (int i = 0; i < WINDOW; i++)
				if (magnitude(int'(moves[i])) <= int'(thresh))
					longmv = 0;
			for (int i = 0; i < WINDOW - 1; i++)
				total += int'(moves[i]);
			for (int i = WINDOW - 1; i > 0; i--)
				moves[i] = moves[i-1];
			moves[0] = delta[DIFF_W-1:0];
			last_dist = d;
			if (changed) begin
				interval = fast;
			end else if (interval < ceiling) begin
				nxt = int'(interval) + int'(step);
				interval = nxt > int'(ceiling) ? ceiling : nxt[INTV_W-1:0];
			end
			bar = int'(d) / 4;
			if (bar > int'(BAR_MAX))
				bar = int'(BAR_MAX);
			r.distance_changed = changed;
			r.long_move = longmv;
			r.change_sum = total[SUM_W-1:0];
			r.bar_length = bar[BAR_W-1:0];
			r.next_interval = interval;
			pending_q.push_back(r);
		endfunction

		function void check_result(motion_result_t got);
			motion_result_t want;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result item, got changed %0b long %0b sum %0d bar %0d intv %0d",
					$time, got.distance_changed, got.long_move, $signed(got.change_sum),
					got.bar_length, got.next_interval);
				errors++;
				return;
			end
			want = pending_q.pop_front();
			checked++;
			if (want.distance_changed)
				n_changed++;
			if (want.long_move)
				n_long++;
			if (got.distance_changed !== want.distance_changed) begin
				$display("%0t: distance_changed expected %0b actual %0b", $time,
					want.distance_changed, got.distance_changed);
				errors++;
			end
			if (got.long_move !== want.long_move) begin
				$display("%0t: long_move expected %0b actual %0b", $time,
					want.long_move, got.long_move);
				errors++;
			end
			if (got.change_sum !== want.change_sum) begin
				$display("%0t: change_sum expected %0d actual %0d", $time,
					$signed(want.change_sum), $signed(got.change_sum));
				errors++;
			end
			if (got.bar_length !== want.bar_length) begin
				$display("%0t: bar_length expected %0d actual %0d", $time,
					want.bar_length, got.bar_length);
				errors++;
			end
			if (got.next_interval !== want.next_interval) begin
				$display("%0t: next_interval expected %0d actual %0d", $time,
					want.next_interval, got.next_interval);
				errors++;
			end
		endfunction

		function int pending();
			return pending_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [DIST_W-1:0] distance = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic distance_changed;
	logic long_move;
	logic signed [SUM_W-1:0] change_sum;
	logic [BAR_W-1:0] bar_length;
	logic [INTV_W-1:0] next_interval;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	motion_scoreboard board;
	int send_gap_pct = 0;
	int stall_pct = 0;
	int idle_cycles = 0;
	int gen_thresh = int'(THRESH_RST);
	int n_settings = 1;
	logic [DIST_W-1:0] last_sent = '0;

	distance_motion_detector uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.distance(distance),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.distance_changed(distance_changed),
		.long_move(long_move),
		.change_sum(change_sum),
		.bar_length(bar_length),
		.next_interval(next_interval),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		motion_result_t got;
		if (out_valid && !out_stall) begin
			got.distance_changed = distance_changed;
			got.long_move = long_move;
			got.change_sum = change_sum;
			got.bar_length = bar_length;
			got.next_interval = next_interval;
			board.check_result(got);
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_sample(input logic [DIST_W-1:0] d);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		distance <= d;
		do @(posedge clk); while (in_stall);
		board.note_sample(d);
		last_sent = d;
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	task automatic write_register(input logic [IDX_W-1:0] idx, input int value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {(DATA_W-CFG_W)'($urandom_range(32'h3f_ffff)), value[CFG_W-1:0]};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.set_register(idx, value[CFG_W-1:0]);
	endtask

	task automatic apply_setting(input int thr, input int fast, input int step, input int ceil);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_register(REG_THRESH, thr);
		write_register(REG_FAST, fast);
		write_register(REG_STEP, step);
		write_register(REG_MAX, ceil);
		gen_thresh = thr;
		n_settings++;
	endtask

	function automatic logic [DIST_W-1:0] next_distance(input int mode);
		int last, m, d;
		last = int'(last_sent);
		case (mode)
			0: begin
				m = $urandom_range(0, gen_thresh + 1 > 1023 ? 1023 : gen_thresh + 1);
				d = $urandom_range(1) ? last + m : last - m;
				if (d < 0)
					d = 0;
				if (d > 1023)
					d = 1023;
			end
			1: begin
				m = gen_thresh + 1 + $urandom_range(0, 60);
				if ($urandom_range(1) && last + m <= 1023)
					d = last + m;
				else if (last >= m)
					d = last - m;
				else if (last + m <= 1023)
					d = last + m;
				else
					d = $urandom_range(0, 1023);
			end
			2: d = $urandom_range(0, 1023);
			default: d = $urandom_range(1) ? 1023 : 0;
		endcase
		return d[DIST_W-1:0];
	endfunction

	localparam int OPENING [24] = '{0, 2, 5, 5, 59, 60, 63, 64, 1023, 0, 1023, 0, 1023, 0,
		0, 1, 3, 3, 1022, 1023, 1020, 1023, 1023, 512};

	initial begin
		int setting [6][4];
		int burst_left, mode, roll;
		board = new();
		setting = '{'{0, 0, 1023, 1023}, '{1023, 1023, 0, 0}, '{3, 1000, 7, 100},
			'{0, 0, 0, 0}, '{8, 50, 30, 500}, '{1, 20, 1023, 1000}};
		setting[3][0] = $urandom_range(0, 40);
		setting[3][1] = $urandom_range(0, 1023);
		setting[3][2] = $urandom_range(0, 200);
		setting[3][3] = $urandom_range(0, 1023);
		burst_left = 0;
		mode = 0;
		send_gap_pct = 25;
		stall_pct = 55;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (OPENING[i])
			send_sample(OPENING[i][DIST_W-1:0]);
		for (int p = 0; p < 6; p++) begin
			apply_setting(setting[p][0], setting[p][1], setting[p][2], setting[p][3]);
			if (p < 2) begin
				send_gap_pct = 25;
				stall_pct = 55;
			end else if (p < 4) begin
				send_gap_pct = 55;
				stall_pct = 25;
			end else begin
				send_gap_pct = 0;
				stall_pct = 0;
			end
			for (int i = 0; i < SAMPLES_PER_SETTING; i++) begin
				if (p == 0 && i == SAMPLES_PER_SETTING / 2)
					wait_for_results();
				if (burst_left == 0) begin
					roll = $urandom_range(99);
					mode = roll < 40 ? 0 : roll < 75 ? 1 : roll < 90 ? 2 : 3;
					burst_left = $urandom_range(1, 12);
				end
				burst_left--;
				send_sample(next_distance(mode));
			end
		end
		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d samples checked under %0d register settings", board.checked, n_settings);
		$display("%0d flagged changes, %0d long moves, %0d mismatches",
			board.n_changed, board.n_long, board.errors);
		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
